// ===== sv/smac_pkg.sv =====
// Shared types and constants of the moving-average crossover detector.
// Used by sma_crossover_signal and its port checker; depends on nothing else.
package smac_pkg;

  localparam int SUM_W       = 40;   // running sums wrap at this width
  localparam int PRICE_W     = 32;   // price field on the input stream
  localparam int CFG_W       = 9;    // window register field
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 88;   // 2 + 40 + 40, padded to whole bytes
  localparam int OUT_TUSER_W = 2;

  localparam int DEF_MAX_WINDOW = 256;
  localparam int DEF_PRICE_BITS = 32;

  localparam logic [CFG_W-1:0] SHORT_WINDOW_RST = 9'd10;
  localparam logic [CFG_W-1:0] LONG_WINDOW_RST  = 9'd30;

  typedef enum logic [0:0] {
    REG_SHORT_WINDOW = 1'b0,
    REG_LONG_WINDOW  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SIG_HOLD = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } signal_t;

  typedef enum logic [1:0] {
    REL_UNKNOWN = 2'd0,
    REL_BELOW   = 2'd1,
    REL_EQUAL   = 2'd2,
    REL_ABOVE   = 2'd3
  } rel_t;

endpackage

// ===== sv/sma_crossover_signal.sv =====
// Dual simple-moving-average crossover detector: price ring, two running sums,
// cross-multiplied compare and buy/sell signal. Depends on smac_pkg.
//
//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   tdata: price; tuser: restart
//  out_     out  out_tvalid/out_tready tdata: signal, short_sum, long_sum; tuser: valids
//  cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data (window length)
//
// One request per cycle unless a held result or a waiting cfg write stalls it. Accepted samples
// pass the ring read at acceptance, sum update, cross multiply and compare into the output register (out_tvalid).
// The ring has two read ports and one write port; a leaving slot equals the write slot
// only for a window of MAX_WINDOW, and the read then returns the old sample as needed.
// in_tready drops during reset, while cfg_valid is high, and while a result is held with
// out_tready low; cfg_ready rises only once the pipe is empty. Reset is synchronous with
// no clearing pass: ring slots are read only after a write since the last restart.
module sma_crossover_signal #(
  parameter int MAX_WINDOW = smac_pkg::DEF_MAX_WINDOW,
  parameter int PRICE_BITS = smac_pkg::DEF_PRICE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [31:0] price
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [smac_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: [0] restart
  input  logic                                in_tuser,
  // out_tdata: [1:0] signal, [41:2] short_sum, [81:42] long_sum, [87:82] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [smac_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: [0] short_valid, [1] long_valid
  output logic [smac_pkg::OUT_TUSER_W-1:0]    out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [smac_pkg::CFG_W-1:0]          cfg_data
);
  import smac_pkg::*;

  localparam int PW     = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int PROD_W = SUM_W + WIN_W;
  localparam int PAD_W  = OUT_TDATA_W - 2 - 2 * SUM_W;

  localparam logic [WIN_W-1:0] MAX_WIN = WIN_W'(MAX_WINDOW);
  localparam logic [AW-1:0]    LAST_WP = AW'(MAX_WINDOW - 1);

  function automatic logic [WIN_W-1:0] clamp_win(input logic [CFG_W-1:0] v);
    logic [WIN_W-1:0] res;
    if (v == '0) begin
      res = WIN_W'(1);
    end else if (32'(v) > MAX_WINDOW) begin
      res = MAX_WIN;
    end else begin
      res = WIN_W'(v);
    end
    return res;
  endfunction

  // slot that lies win samples before wp in the ring
  function automatic logic [AW-1:0] leave_idx(input logic [AW-1:0] wp,
                                              input logic [WIN_W-1:0] win);
    logic [WIN_W-1:0] wp_ext;
    logic [WIN_W-1:0] diff;
    wp_ext = WIN_W'(wp);
    if (wp_ext >= win) begin
      diff = wp_ext - win;
    end else begin
      diff = MAX_WIN - (win - wp_ext);
    end
    return diff[AW-1:0];
  endfunction

  logic [PW-1:0] ring [MAX_WINDOW];

  // window registers and stream state
  logic [WIN_W-1:0] sw_r, lw_r;
  logic [AW-1:0]    wp_r;
  logic [WIN_W-1:0] cnt_r;
  logic [SUM_W-1:0] s_sum_r, l_sum_r;
  rel_t             prev_rel_r;

  // stage 1: ring read in flight
  logic             p1_valid_r, p1_clr_r, p1_drop_s_r, p1_drop_l_r, p1_sv_r, p1_lv_r;
  logic [PW-1:0]    p1_price_r, rd_s_r, rd_l_r;
  // stage 2: sums in s_sum_r / l_sum_r
  logic             p2_valid_r, p2_clr_r, p2_sv_r, p2_lv_r;
  // stage 3: cross products
  logic             p3_valid_r, p3_clr_r, p3_sv_r, p3_lv_r;
  logic [SUM_W-1:0] p3_s_r, p3_l_r;
  logic [PROD_W-1:0] a_r, b_r;
  // output register
  logic             out_valid_r;
  signal_t          out_sig_r;
  logic [SUM_W-1:0] out_s_r, out_l_r;
  logic             out_sv_r, out_lv_r;

  logic             adv, in_acc, cfg_acc, pipe_empty;
  logic [AW-1:0]    wp_eff, wp_nxt, idx_s, idx_l;
  logic [WIN_W-1:0] cnt_eff, cnt_nxt;
  logic [SUM_W-1:0] s_sum_nxt, l_sum_nxt;
  rel_t             rel, prev;
  signal_t          sig;

  assign adv        = !out_valid_r || out_tready;
  assign pipe_empty = !p1_valid_r && !p2_valid_r && !p3_valid_r && !out_valid_r;
  // a waiting window write holds the input off so it lands on an empty pipe
  assign in_tready  = rst_n && adv && !cfg_valid;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = rst_n && pipe_empty;
  assign cfg_acc    = cfg_valid && cfg_ready;

  // stage 0: restart takes effect before this sample
  always_comb begin
    wp_eff  = in_tuser ? '0 : wp_r;
    cnt_eff = in_tuser ? '0 : cnt_r;
    wp_nxt  = (wp_eff == LAST_WP) ? '0 : wp_eff + AW'(1);
    cnt_nxt = (cnt_eff == MAX_WIN) ? cnt_eff : cnt_eff + WIN_W'(1);
    idx_s   = leave_idx(wp_eff, sw_r);
    idx_l   = leave_idx(wp_eff, lw_r);
  end

  // stage 1: fold the leaving samples out and the new one in
  always_comb begin
    s_sum_nxt = (p1_clr_r ? '0 : s_sum_r) - (p1_drop_s_r ? SUM_W'(rd_s_r) : '0)
                + SUM_W'(p1_price_r);
    l_sum_nxt = (p1_clr_r ? '0 : l_sum_r) - (p1_drop_l_r ? SUM_W'(rd_l_r) : '0)
                + SUM_W'(p1_price_r);
  end

  // stage 3: relation and crossing
  always_comb begin
    if (p3_sv_r && p3_lv_r) begin
      if (a_r > b_r) begin
        rel = REL_ABOVE;
      end else if (a_r < b_r) begin
        rel = REL_BELOW;
      end else begin
        rel = REL_EQUAL;
      end
    end else begin
      rel = REL_UNKNOWN;
    end
    prev = p3_clr_r ? REL_UNKNOWN : prev_rel_r;
    sig  = SIG_HOLD;
    if (rel != REL_UNKNOWN && prev != REL_UNKNOWN) begin
      if (rel == REL_ABOVE && prev != REL_ABOVE) begin
        sig = SIG_BUY;
      end else if (rel == REL_BELOW && prev != REL_BELOW) begin
        sig = SIG_SELL;
      end
    end
  end

  // ring: write at acceptance, both leaving slots read in the same cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring[wp_eff] <= in_tdata[PW-1:0];
    end
    if (adv) begin
      rd_s_r <= ring[idx_s];
      rd_l_r <= ring[idx_l];
    end
  end

  // control and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r        <= clamp_win(SHORT_WINDOW_RST);
      lw_r        <= clamp_win(LONG_WINDOW_RST);
      wp_r        <= '0;
      cnt_r       <= '0;
      s_sum_r     <= '0;
      l_sum_r     <= '0;
      prev_rel_r  <= REL_UNKNOWN;
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (cfg_acc) begin
      // cfg_ready admits writes only on an empty pipe
      unique case (cfg_reg_t'(cfg_index))
        REG_SHORT_WINDOW: sw_r <= clamp_win(cfg_data);
        default:          lw_r <= clamp_win(cfg_data);
      endcase
      wp_r       <= '0;
      cnt_r      <= '0;
      s_sum_r    <= '0;
      l_sum_r    <= '0;
      prev_rel_r <= REL_UNKNOWN;
    end else if (adv) begin
      p1_valid_r  <= in_acc;
      p2_valid_r  <= p1_valid_r;
      p3_valid_r  <= p2_valid_r;
      out_valid_r <= p3_valid_r;
      if (in_acc) begin
        wp_r  <= wp_nxt;
        cnt_r <= cnt_nxt;
      end
      if (p1_valid_r) begin
        s_sum_r <= s_sum_nxt;
        l_sum_r <= l_sum_nxt;
      end
      if (p3_valid_r) begin
        prev_rel_r <= rel;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_price_r  <= in_tdata[PW-1:0];
      p1_clr_r    <= in_tuser;
      p1_drop_s_r <= cnt_eff >= sw_r;
      p1_drop_l_r <= cnt_eff >= lw_r;
      p1_sv_r     <= cnt_nxt >= sw_r;
      p1_lv_r     <= cnt_nxt >= lw_r;

      p2_clr_r <= p1_clr_r;
      p2_sv_r  <= p1_sv_r;
      p2_lv_r  <= p1_lv_r;

      p3_clr_r <= p2_clr_r;
      p3_sv_r  <= p2_sv_r;
      p3_lv_r  <= p2_lv_r;
      p3_s_r   <= s_sum_r;
      p3_l_r   <= l_sum_r;
      a_r      <= PROD_W'(s_sum_r) * PROD_W'(lw_r);
      b_r      <= PROD_W'(l_sum_r) * PROD_W'(sw_r);

      if (p3_valid_r) begin
        out_sig_r <= sig;
        out_s_r   <= p3_s_r;
        out_l_r   <= p3_l_r;
        out_sv_r  <= p3_sv_r;
        out_lv_r  <= p3_lv_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_l_r, out_s_r, out_sig_r};
  assign out_tuser  = {out_lv_r, out_sv_r};

endmodule

// ===== sv/smac_checker.sv =====
// Port-level checks on the result stream of sma_crossover_signal.
// Depends on smac_pkg; attached to every sma_crossover_signal instance by the bind below.
module smac_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [smac_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [smac_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import smac_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no result survives a reset
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_sig_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] <= SIG_SELL)
    else $error("signal code out of range");

  // a crossing needs both windows full
  a_sig_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != SIG_HOLD |-> out_tuser == 2'b11)
    else $error("crossing reported before windows filled");

endmodule

bind sma_crossover_signal smac_checker u_smac_checker (.*);
